FILE: design/xed_pkg.sv
// Shared constants, types and helper functions for the XML entity decoder.
`default_nettype none

package xed_pkg;

   // Sizes of the decoder's internal stores.
   localparam int unsigned GRP_MAX     = 6;   // decoded bytes one input word can cause
   localparam int unsigned NAME_NUM    = 5;   // named entities recognized
   localparam int unsigned HELD_DEPTH  = 5;   // longest held named prefix
   localparam int unsigned VALUE_W     = 63;  // numeric value never exceeds 2^63-1
   localparam int unsigned QUEUE_DEPTH = 4;   // default depth of the group queue

   // Parser modes.
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_NAMED = 2'd1;
   localparam logic [1:0] MODE_NUMHD = 2'd2;
   localparam logic [1:0] MODE_NUMDG = 2'd3;

   // Characters with a special role.
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_X_LO = 8'h78;
   localparam logic [7:0] CH_X_UP = 8'h58;
   localparam logic [7:0] CH_SAT  = 8'hFF;

   // Entity spellings, first character in the top byte.
   localparam logic [NAME_NUM-1:0][47:0] ENT_TEXT = {
      {"&apos;"},
      {"&quot;"},
      {"&gt;", 16'h0000},
      {"&lt;", 16'h0000},
      {"&amp;", 8'h00}
   };
   localparam logic [NAME_NUM-1:0][2:0] ENT_LEN  = {3'd6, 3'd6, 3'd4, 3'd4, 3'd5};
   localparam logic [NAME_NUM-1:0][7:0] ENT_CHAR = {8'h27, 8'h22, 8'h3E, 8'h3C, 8'h26};

   // One group of decoded bytes caused by a single input word.
   typedef struct packed {
      logic [GRP_MAX-1:0][7:0] bytes;
      logic [2:0]              cnt;
      logic                    last;
   } group_type;

   // Character at position pos of entity idx.
   function automatic logic [7:0] ent_at(input logic [2:0] idx, input logic [2:0] pos);
      logic [47:0] w;
      w = ENT_TEXT[idx] << {pos, 3'b000};
      return w[47:40];
   endfunction

   // Digit value of a byte: bit 4 flags a valid digit of the base.
   function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (hex && b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (hex && b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/xed_chan_if.sv
// Handshake channel interfaces for raw and decoded text words.
`default_nettype none

interface xed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface xed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

FILE: design/xed_front.sv
// Front end: accepts one raw word per cycle while the group queue has room, parses it and forms its output group.
`default_nettype none

module xed_front import xed_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   xed_req_if.sink    req_ch,
   input  wire logic  q_full,
   output logic       push,
   output group_type  grp
);

   logic [1:0]                    mode_ff, mode_in;
   logic [HELD_DEPTH-1:0][7:0]    held_ff, held_in;
   logic [2:0]                    held_cnt_ff, held_cnt_in;
   logic [VALUE_W-1:0]            value_ff, value_in;
   logic                          hex_ff, hex_in;
   logic                          sat_ff, sat_in;
   logic                          accept;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;

   // Full parse step for the offered word: next state plus emitted bytes.
   always_comb begin : step_logic
      logic [7:0]         b;
      logic [2:0]         n;
      logic               redo;
      logic               digits;
      logic               full_hit;
      logic               prefix;
      logic               ok;
      logic [7:0]         full_char;
      logic [4:0]         dig;
      logic [VALUE_W+4:0] prod;

      b           = req_ch.in_byte;
      n           = 3'd0;
      redo        = 1'b0;
      digits      = 1'b0;
      full_hit    = 1'b0;
      prefix      = 1'b0;
      ok          = 1'b0;
      full_char   = 8'h00;
      dig         = 5'd0;
      prod        = '0;
      mode_in     = mode_ff;
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      value_in    = value_ff;
      hex_in      = hex_ff;
      sat_in      = sat_ff;
      grp.bytes   = '0;

      case (mode_ff)
         MODE_NAMED: begin
            // Try to extend the held prefix against every entity.
            for (int k = 0; k < NAME_NUM; k++) begin
               if (held_cnt_ff < ENT_LEN[k]) begin
                  ok = 1'b1;
                  for (int i = 0; i < HELD_DEPTH; i++) begin
                     if (3'(i) < held_cnt_ff && held_ff[i] != ent_at(3'(k), 3'(i))) begin
                        ok = 1'b0;
                     end
                  end
                  if (ent_at(3'(k), held_cnt_ff) != b) begin
                     ok = 1'b0;
                  end
                  if (ok) begin
                     if ((held_cnt_ff + 3'd1) == ENT_LEN[k]) begin
                        full_hit  = 1'b1;
                        full_char = ENT_CHAR[k];
                     end else begin
                        prefix = 1'b1;
                     end
                  end
               end
            end
            if (full_hit) begin
               held_cnt_in = 3'd0;
               mode_in     = MODE_IDLE;
               grp.bytes[n] = full_char;
               n = n + 3'd1;
            end else if (prefix && held_cnt_ff < 3'(HELD_DEPTH)) begin
               held_in[held_cnt_ff] = b;
               held_cnt_in = held_cnt_ff + 3'd1;
            end else if (held_cnt_ff == 3'd1 && b == CH_HASH) begin
               held_cnt_in = 3'd0;
               value_in    = '0;
               sat_in      = 1'b0;
               hex_in      = 1'b0;
               mode_in     = MODE_NUMHD;
            end else begin
               // Failed match: the prefix goes out literally, the byte is parsed anew.
               for (int i = 0; i < HELD_DEPTH; i++) begin
                  if (3'(i) < held_cnt_ff && n < 3'(GRP_MAX)) begin
                     grp.bytes[n] = held_ff[i];
                     n = n + 3'd1;
                  end
               end
               held_cnt_in = 3'd0;
               mode_in     = MODE_IDLE;
               redo        = 1'b1;
            end
         end
         MODE_NUMHD: begin
            mode_in = MODE_NUMDG;
            if (b == CH_X_LO || b == CH_X_UP) begin
               hex_in = 1'b1;
            end else begin
               hex_in = 1'b0;
               digits = 1'b1;
            end
         end
         MODE_NUMDG: begin
            digits = 1'b1;
         end
         default: begin
            redo = 1'b1;
         end
      endcase

      // Digit accumulation with saturation, or the end of the number.
      if (digits) begin
         dig = digit_of(b, hex_in);
         if (dig[4]) begin
            if (hex_in) begin
               prod = {5'd0, value_ff} << 4;
            end else begin
               prod = ({5'd0, value_ff} << 3) + ({5'd0, value_ff} << 1);
            end
            prod = prod + {{(VALUE_W+1){1'b0}}, dig[3:0]};
            if (!sat_ff) begin
               if (|prod[VALUE_W+4:VALUE_W]) begin
                  sat_in = 1'b1;
               end else begin
                  value_in = prod[VALUE_W-1:0];
               end
            end
         end else begin
            grp.bytes[n] = sat_ff ? CH_SAT : value_ff[7:0];
            n = n + 3'd1;
            value_in = '0;
            sat_in   = 1'b0;
            hex_in   = 1'b0;
            mode_in  = MODE_IDLE;
            if (b != CH_SEMI) begin
               redo = 1'b1;
            end
         end
      end

      // Parse the byte from the idle mode.
      if (redo) begin
         if (b == CH_AMP) begin
            held_in[0]  = b;
            held_cnt_in = 3'd1;
            mode_in     = MODE_NAMED;
         end else begin
            mode_in = MODE_IDLE;
            if (n < 3'(GRP_MAX)) begin
               grp.bytes[n] = b;
               n = n + 3'd1;
            end
         end
      end

      // End of stream flushes whatever is pending.
      if (req_ch.in_last) begin
         if (mode_in == MODE_NAMED) begin
            for (int i = 0; i < HELD_DEPTH; i++) begin
               if (3'(i) < held_cnt_in && n < 3'(GRP_MAX)) begin
                  grp.bytes[n] = held_in[i];
                  n = n + 3'd1;
               end
            end
         end else if (mode_in == MODE_NUMHD || mode_in == MODE_NUMDG) begin
            if (n < 3'(GRP_MAX)) begin
               grp.bytes[n] = sat_in ? CH_SAT : value_in[7:0];
               n = n + 3'd1;
            end
            value_in = '0;
            sat_in   = 1'b0;
            hex_in   = 1'b0;
         end
         mode_in     = MODE_IDLE;
         held_cnt_in = 3'd0;
      end

      grp.cnt  = n;
      grp.last = req_ch.in_last;
   end

   assign push = accept && (grp.cnt != 3'd0);

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         held_cnt_ff <= 3'd0;
         value_ff    <= '0;
         hex_ff      <= 1'b0;
         sat_ff      <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         held_cnt_ff <= held_cnt_in;
         value_ff    <= value_in;
         hex_ff      <= hex_in;
         sat_ff      <= sat_in;
      end
   end

   // Held prefix bytes carry no reset; only entries below the count are read.
   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

`ifndef SYNTHESIS
   // A word with the end marker leaves the parser idle with nothing held.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.in_last |=> mode_ff == MODE_IDLE && held_cnt_ff == 3'd0)
      else $error("parser not idle after end of stream");

   // A pushed group never holds more bytes than the group can carry.
   a_group_size: assert property (@(posedge clock) disable iff (reset)
      push |-> grp.cnt <= 3'(GRP_MAX))
      else $error("group byte count out of range");
`endif

endmodule

`default_nettype wire

FILE: design/xed_queue.sv
// Short queue of decoded groups between the front end and the back end.
`default_nettype none

module xed_queue import xed_pkg::*; #(
   parameter int unsigned Depth = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire group_type  push_grp,
   input  wire logic       pop,
   output logic            full,
   output logic            not_empty,
   output group_type       head
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   group_type            mem_ff [Depth];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;

   assign full      = (cnt_ff == CntW'(Depth));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   // Pointer and count updates with explicit wrap.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Group storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_grp;
      end
   end

`ifndef SYNTHESIS
   // The front end must never push into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full group queue");

   // Occupancy stays within the queue depth.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(Depth))
      else $error("group queue count out of range");
`endif

endmodule

`default_nettype wire

FILE: design/xed_back.sv
// Back end: drains queued groups one decoded word per cycle into the output register while rsp_ch takes its words.
`default_nettype none

module xed_back import xed_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       not_empty,
   input  wire group_type  head,
   output logic            pop,
   xed_rsp_if.source       rsp_ch
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [2:0] idx_ff, idx_in;
   logic       load;
   logic       take;
   logic       grp_end;

   assign load    = !valid_ff || rsp_ch.ready;
   assign take    = load && not_empty;
   assign grp_end = ((idx_ff + 3'd1) == head.cnt);
   assign pop     = take && grp_end;

   // Pick the next byte of the head group.
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = head.bytes[idx_ff];
         last_in  = head.last && grp_end;
         idx_in   = grp_end ? 3'd0 : idx_ff + 3'd1;
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // Output word payload carries no reset.
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.out_byte = byte_ff;
   assign rsp_ch.out_last = last_ff;

`ifndef SYNTHESIS
   // The drain index always points inside a non-empty head group.
   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      not_empty |-> head.cnt != 3'd0 && idx_ff < head.cnt)
      else $error("drain index outside head group");
`endif

endmodule

`default_nettype wire

FILE: design/xml_entity_decoder_core.sv
// Top level of the streaming XML entity decoder.
//
//   channel  | direction | handshake           | word
//   req_ch   | in        | valid/ready         | in_byte[7:0], in_last
//   rsp_ch   | out       | valid/ready         | out_byte[7:0], out_last
//
// One raw word is accepted per cycle while the group queue has room.
// A raw word that decodes to k words fills the output register with each of them in turn;
// the QueueDepth-entry group queue absorbs these bursts.
// A decoded word passes through the group queue storage and then the output register before it is valid on rsp_ch.
// req_ch.ready drops only while the group queue is full; rsp_ch stalls back up into it.
// Synchronous reset returns the parser to idle and empties queue and output.
`default_nettype none

module xml_entity_decoder_core import xed_pkg::*; #(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   xed_req_if.sink    req_ch,
   xed_rsp_if.source  rsp_ch
);

   logic      push;
   logic      pop;
   logic      q_full;
   logic      q_not_empty;
   group_type push_grp;
   group_type head_grp;

   xed_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .push   (push),
      .grp    (push_grp)
   );

   xed_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_grp  (push_grp),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head_grp)
   );

   xed_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (q_not_empty),
      .head      (head_grp),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire
